// ===== rtl/core/csbwq_pkg.sv =====
// shared types, codes and defaults of the semaphore bank with wait queues
package csbwq_pkg;

	// default configuration
	localparam int NUM_SEMS_DEF    = 5;
	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int PID_BITS_DEF    = 8;

	// action codes
	localparam logic [2:0] ACT_CREATE = 3'd0;
	localparam logic [2:0] ACT_WAIT   = 3'd1;
	localparam logic [2:0] ACT_SIGNAL = 3'd2;
	localparam logic [2:0] ACT_FIND   = 3'd3;
	localparam logic [2:0] ACT_REMOVE = 3'd4;

	// status codes
	localparam logic [2:0] STS_OK          = 3'd0;
	localparam logic [2:0] STS_BAD_INDEX   = 3'd1;
	localparam logic [2:0] STS_NEG_INIT    = 3'd2;
	localparam logic [2:0] STS_EXISTS      = 3'd3;
	localparam logic [2:0] STS_NOT_CREATED = 3'd4;
	localparam logic [2:0] STS_FULL        = 3'd5;
	localparam logic [2:0] STS_NOT_FOUND   = 3'd6;

	// request transaction
	typedef struct packed {
		logic [2:0]        action;
		logic [2:0]        sem_index;
		logic signed [7:0] init_count;
		logic [7:0]        proc_id;
	} req_t;

	// response transaction
	typedef struct packed {
		logic [2:0] status;
		logic       woken_valid;
		logic [7:0] woken_pid;
		logic [2:0] found_sem;
		logic       all_queues_empty;
	} rsp_t;

endpackage

// ===== rtl/core/csbwq_store.sv =====
// waiter memory: one write port, one read port with registered data
module csbwq_store #(
	parameter int AW = 7,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	localparam int DEPTH = 1 << AW;

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data registered when rd_en is high
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== rtl/core/counting_semaphore_bank_with_wait_queues.sv =====
// Bank of counting semaphores, each with a FIFO of waiting pids held in one
// synchronous memory laid out as one row of 2**ceil(log2(QUEUE_DEPTH)) slots
// per semaphore. Create, wait and invalid requests go from idle straight to
// the finish state, which loads the response register. Signal with a released
// waiter reads the oldest slot and then moves every newer entry down one
// slot, each entry read and then written back. Find walks the queues one
// memory read per entry, semaphore by semaphore; find and remove adds the
// same move-down pass as signal. One request is in work at a time; the next
// is taken once the response is written to the output register, even while
// that response is still stalled.
module counting_semaphore_bank_with_wait_queues #(
	parameter int NUM_SEMS    = csbwq_pkg::NUM_SEMS_DEF,
	parameter int QUEUE_DEPTH = csbwq_pkg::QUEUE_DEPTH_DEF,
	parameter int PID_BITS    = csbwq_pkg::PID_BITS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  csbwq_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output csbwq_pkg::rsp_t rsp
);
	import csbwq_pkg::*;

	localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW = SW + QW;

	// sequencer states
	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SIG_RD   = 3'd1;
	localparam logic [2:0] ST_SRCH_SEM = 3'd2;
	localparam logic [2:0] ST_SRCH_CMP = 3'd3;
	localparam logic [2:0] ST_DROP_CHK = 3'd4;
	localparam logic [2:0] ST_DROP_WR  = 3'd5;
	localparam logic [2:0] ST_FIN      = 3'd6;

	logic [2:0]          state_q;
	logic                created_q [NUM_SEMS];
	logic signed [15:0]  count_q [NUM_SEMS];
	logic [LW-1:0]       len_q [NUM_SEMS];
	logic [SW:0]         sem_q;
	logic [LW-1:0]       pos_q;
	logic [2:0]          act_q;
	logic [PID_BITS-1:0] pid_q;
	rsp_t                res_q;
	rsp_t                rsp_q;
	logic                rsp_valid_q;

	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [PID_BITS-1:0] wr_data;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [PID_BITS-1:0] rd_data;

	logic                accept;
	logic                idx_ok;
	logic                bad;
	logic [SW-1:0]       a_idx;
	logic                a_cr;
	logic signed [15:0]  a_cnt;
	logic [LW-1:0]       a_len;
	logic signed [15:0]  w_next;
	logic signed [15:0]  s_next;
	logic                push;
	logic                pop;
	logic [SW-1:0]       s_idx;
	logic                s_end;
	logic                s_cr;
	logic [LW-1:0]       s_len;
	logic                scan_start;
	logic                hit;
	logic                scan_step;
	logic [LW-1:0]       pos_nx;
	logic                move;
	logic                all_empty;
	rsp_t                res_d;
	rsp_t                fin_rsp;
	logic                rsp_load;

	csbwq_store #(
		.AW(AW),
		.DW(PID_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	// request decode
	always_comb begin
		accept = req_valid && (state_q == ST_IDLE);
		idx_ok = ({1'b0, req.sem_index} < 4'(NUM_SEMS));
		bad    = ((req.action <= ACT_SIGNAL) && !idx_ok) || (req.action > ACT_REMOVE);
		a_idx  = req.sem_index[SW-1:0];
		a_cr   = created_q[a_idx];
		a_cnt  = count_q[a_idx];
		a_len  = len_q[a_idx];
		w_next = (a_cnt == 16'sh8000) ? a_cnt : a_cnt - 16'sd1;
		s_next = (a_cnt == 16'sh7fff) ? a_cnt : a_cnt + 16'sd1;
		push   = accept && !bad && (req.action == ACT_WAIT) && a_cr && w_next[15]
			&& (a_len < LW'(QUEUE_DEPTH));
		pop    = accept && !bad && (req.action == ACT_SIGNAL) && a_cr
			&& (s_next[15] || (s_next == 16'sd0)) && (a_len != '0);
	end

	// scan and move-down control
	always_comb begin
		s_idx      = sem_q[SW-1:0];
		s_end      = (sem_q == (SW+1)'(NUM_SEMS));
		s_cr       = created_q[s_idx];
		s_len      = len_q[s_idx];
		scan_start = (state_q == ST_SRCH_SEM) && !s_end && s_cr && (s_len != '0);
		hit        = (rd_data == pid_q);
		scan_step  = (state_q == ST_SRCH_CMP) && !hit && (pos_q != '0);
		pos_nx     = pos_q + LW'(1);
		move       = (state_q == ST_DROP_CHK) && (pos_nx < s_len);
	end

	// memory port control
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = {s_idx, pos_q[QW-1:0]};
		wr_data = rd_data;
		rd_en   = 1'b0;
		rd_addr = {s_idx, pos_nx[QW-1:0]};
		if (push) begin
			wr_en   = 1'b1;
			wr_addr = {a_idx, a_len[QW-1:0]};
			wr_data = PID_BITS'(req.proc_id);
		end else if (state_q == ST_DROP_WR) begin
			wr_en = 1'b1;
		end
		if (pop) begin
			rd_en   = 1'b1;
			rd_addr = {a_idx, QW'(0)};
		end else if (scan_start) begin
			rd_en   = 1'b1;
			rd_addr = {s_idx, QW'(s_len - LW'(1))};
		end else if (scan_step) begin
			rd_en   = 1'b1;
			rd_addr = {s_idx, QW'(pos_q - LW'(1))};
		end else if (move) begin
			rd_en = 1'b1;
		end
	end

	// empty flag over all created semaphores
	always_comb begin
		all_empty = 1'b1;
		for (int i = 0; i < NUM_SEMS; i++) begin
			if (created_q[i] && (len_q[i] != '0)) begin
				all_empty = 1'b0;
			end
		end
	end

	// next response contents
	always_comb begin
		res_d = res_q;
		if (accept) begin
			res_d = '0;
			if (bad) begin
				res_d.status = STS_BAD_INDEX;
			end else begin
				unique case (req.action)
					ACT_CREATE: begin
						if (req.init_count < 0) begin
							res_d.status = STS_NEG_INIT;
						end else if (a_cr) begin
							res_d.status = STS_EXISTS;
						end
					end
					ACT_WAIT: begin
						if (!a_cr) begin
							res_d.status = STS_NOT_CREATED;
						end else if (w_next[15] && !push) begin
							res_d.status = STS_FULL;
						end
					end
					ACT_SIGNAL: begin
						if (!a_cr) begin
							res_d.status = STS_NOT_CREATED;
						end
					end
					default: begin
					end
				endcase
			end
		end else if (state_q == ST_SIG_RD) begin
			res_d.woken_valid = 1'b1;
			res_d.woken_pid   = 8'(rd_data);
		end else if ((state_q == ST_SRCH_SEM) && s_end) begin
			res_d.status = STS_NOT_FOUND;
		end else if ((state_q == ST_SRCH_CMP) && hit) begin
			res_d.woken_pid = 8'(pid_q);
			res_d.found_sem = 3'(sem_q);
		end
		fin_rsp                  = res_q;
		fin_rsp.all_queues_empty = all_empty;
	end

	// sequencer and semaphore state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			sem_q       <= '0;
			pos_q       <= '0;
			act_q       <= ACT_CREATE;
			pid_q       <= '0;
			res_q       <= '0;
			rsp_q       <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				created_q[i] <= 1'b0;
				count_q[i]   <= '0;
				len_q[i]     <= '0;
			end
		end else begin
			res_q <= res_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q <= req.action;
						pid_q <= PID_BITS'(req.proc_id);
						if (bad) begin
							state_q <= ST_FIN;
						end else begin
							unique case (req.action)
								ACT_CREATE: begin
									if (!(req.init_count < 0) && !a_cr) begin
										created_q[a_idx] <= 1'b1;
										count_q[a_idx]   <= 16'(req.init_count);
										len_q[a_idx]     <= '0;
									end
									state_q <= ST_FIN;
								end
								ACT_WAIT: begin
									if (a_cr && !(w_next[15] && !push)) begin
										count_q[a_idx] <= w_next;
										if (push) begin
											len_q[a_idx] <= a_len + LW'(1);
										end
									end
									state_q <= ST_FIN;
								end
								ACT_SIGNAL: begin
									if (a_cr) begin
										count_q[a_idx] <= s_next;
									end
									if (pop) begin
										sem_q   <= {1'b0, a_idx};
										state_q <= ST_SIG_RD;
									end else begin
										state_q <= ST_FIN;
									end
								end
								default: begin
									sem_q   <= '0;
									state_q <= ST_SRCH_SEM;
								end
							endcase
						end
					end
				end
				ST_SIG_RD: begin
					pos_q   <= '0;
					state_q <= ST_DROP_CHK;
				end
				ST_SRCH_SEM: begin
					if (s_end) begin
						state_q <= ST_FIN;
					end else if (scan_start) begin
						pos_q   <= s_len - LW'(1);
						state_q <= ST_SRCH_CMP;
					end else begin
						sem_q <= sem_q + (SW+1)'(1);
					end
				end
				ST_SRCH_CMP: begin
					if (hit) begin
						state_q <= (act_q == ACT_REMOVE) ? ST_DROP_CHK : ST_FIN;
					end else if (pos_q != '0) begin
						pos_q <= pos_q - LW'(1);
					end else begin
						sem_q   <= sem_q + (SW+1)'(1);
						state_q <= ST_SRCH_SEM;
					end
				end
				ST_DROP_CHK: begin
					if (move) begin
						state_q <= ST_DROP_WR;
					end else begin
						len_q[s_idx] <= s_len - LW'(1);
						state_q      <= ST_FIN;
					end
				end
				ST_DROP_WR: begin
					pos_q   <= pos_nx;
					state_q <= ST_DROP_CHK;
				end
				ST_FIN: begin
					if (rsp_load) begin
						rsp_q   <= fin_rsp;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// every taken request leaves idle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("request taken without leaving idle");

	// a response appears only out of the finish state
	a_rsp_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FIN))
		else $error("response raised outside finish state");

	// each move-down write follows its read
	a_drop_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DROP_WR) |-> $past(state_q == ST_DROP_CHK))
		else $error("move-down write without read");

	// a released waiter goes with an ok status
	a_woken_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.woken_valid) |-> (rsp_q.status == STS_OK))
		else $error("woken pid with error status");

endmodule
